// File: hw/rtl/glt_pkg.sv
// Shared types, field layout and constants for the gain-scheduled LQR torque block.
`default_nettype none

package glt_pkg;

    // Table geometry: one wheel row and one hip row per state error
    localparam int STATE_COUNT = 6;
    localparam int POLY_TERMS  = 4;
    localparam int GAIN_ROWS   = 2 * STATE_COUNT;
    localparam int TABLE_DEPTH = GAIN_ROWS * POLY_TERMS;

    // Field widths
    localparam int WORD_W  = 32;
    localparam int INDEX_W = 6;
    localparam int LEN_W   = 17;
    localparam int POW_W   = 31;
    localparam int PROD_W  = 64;

    // Request tdata layout, lowest bit first
    localparam int IDX_LSB    = 0;
    localparam int VALUE_LSB  = IDX_LSB + INDEX_W;
    localparam int LEN_LSB    = VALUE_LSB + WORD_W;
    localparam int OFF_BIT    = LEN_LSB + LEN_W;
    localparam int ERR_LSB    = OFF_BIT + 1;
    localparam int TDATA_IN_W = ((ERR_LSB + STATE_COUNT * WORD_W + 7) / 8) * 8;
    localparam int TUSER_IN_W = 1;

    // Result tdata layout
    localparam int TDATA_OUT_W = 2 * WORD_W;

    // Request kind carried in tuser
    typedef enum logic {
        ACT_LOAD    = 1'b0,
        ACT_COMPUTE = 1'b1
    } action_t;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [POW_W-1:0]         pow_t;
    typedef word_t [STATE_COUNT-1:0]  err_vec_t;
    typedef pow_t [POLY_TERMS-1:0]    pow_vec_t;
    typedef word_t [GAIN_ROWS-1:0]    gain_vec_t;

    // One request as it moves through the power stages
    typedef struct packed {
        action_t             action;
        logic [INDEX_W-1:0]  coef_index;
        word_t               coef_value;
        logic [LEN_W-1:0]    leg_length;
        logic                off_ground;
        err_vec_t            err;
    } item_t;

    // What a compute request still needs once its gains are known
    typedef struct packed {
        logic     off_ground;
        err_vec_t err;
    } ctx_t;

endpackage

`default_nettype wire

// File: hw/rtl/gain_scheduled_lqr_torque.sv
// Top level of the gain-scheduled LQR torque block: input stage and pipeline assembly.
//
// Usage:
//   Requests arrive on the s_ stream. s_tuser selects the kind: a load request
//   writes one Q16.16 word of the 48-entry coefficient table (12 gain rows of
//   4 cubic coefficients, highest power first); a compute request carries the
//   leg length, the off-ground flag and six state errors.
//   Each compute request yields one result on the m_ stream with the wheel and
//   the negated hip torque; load requests yield none.
//   The path has 12 register stages. Throughput is one request per cycle while
//   the receiver does not stall, set by the fully pipelined multipliers (48 gain
//   products and 12 torque products each get their own stage).
//   A table entry must be loaded before a compute request that reads it.
//   Reset clears only the pipeline valid bits; the table content is kept
//   undefined until loaded, and no clearing pass is needed.
//   When the receiver stalls, the result stays on m_tdata and the stages
//   behind it keep filling their empty slots, so requests are still taken
//   until the pipeline is full. Loads never wait at the table.
`default_nettype none

module gain_scheduled_lqr_torque #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // coef_index, coef_value, leg_length, off_ground, theta_error,
    // dtheta_error, pos_error, vel_error, pitch_error, pitch_rate_error
    input  logic [glt_pkg::TDATA_IN_W-1:0]     s_tdata,
    // action
    input  logic [glt_pkg::TUSER_IN_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // wheel_torque, hip_torque
    output logic [glt_pkg::TDATA_OUT_W-1:0]    m_tdata
);
    import glt_pkg::*;

    logic      in_valid_reg;
    item_t     in_item_reg;
    item_t     item_in;
    logic      in_ready;

    logic      pw_ready;
    logic      pw_valid;
    item_t     pw_item;
    pow_vec_t  pw_pow;
    logic      gn_ready;

    logic      gn_valid;
    ctx_t      gn_ctx;
    gain_vec_t gn_gain;
    logic      tq_ready;

    logic [WORD_W-1:0] wheel;
    logic [WORD_W-1:0] hip;

    // Unpack the request
    always_comb
    begin
        item_in.action     = action_t'(s_tuser[0]);
        item_in.coef_index = s_tdata[IDX_LSB +: INDEX_W];
        item_in.coef_value = s_tdata[VALUE_LSB +: WORD_W];
        item_in.leg_length = s_tdata[LEN_LSB +: LEN_W];
        item_in.off_ground = s_tdata[OFF_BIT];
        for (int j = 0; j < STATE_COUNT; j++)
        begin
            item_in.err[j] = s_tdata[ERR_LSB + WORD_W * j +: WORD_W];
        end
    end

    // Input register stage
    assign in_ready = !in_valid_reg || pw_ready;
    assign s_tready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && s_tvalid)
        begin
            in_item_reg <= item_in;
        end
    end

    // Leg-length powers
    glt_power #(
        .FRAC_BITS (FRAC_BITS)
    ) u_power (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_ready  (pw_ready),
        .in_item   (in_item_reg),
        .out_valid (pw_valid),
        .out_ready (gn_ready),
        .out_item  (pw_item),
        .out_pow   (pw_pow)
    );

    // Coefficient table and gain polynomials
    glt_gain #(
        .FRAC_BITS (FRAC_BITS)
    ) u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pw_valid),
        .in_ready  (gn_ready),
        .in_item   (pw_item),
        .in_pow    (pw_pow),
        .out_valid (gn_valid),
        .out_ready (tq_ready),
        .out_ctx   (gn_ctx),
        .out_gain  (gn_gain)
    );

    // Torque dot products and output register
    glt_torque #(
        .FRAC_BITS (FRAC_BITS)
    ) u_torque (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (gn_valid),
        .in_ready  (tq_ready),
        .in_ctx    (gn_ctx),
        .in_gain   (gn_gain),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_wheel (wheel),
        .out_hip   (hip)
    );

    assign m_tdata = {hip, wheel};

endmodule

`default_nettype wire

// File: hw/rtl/glt_power.sv
// Leg-length power chain: one multiply stage and one round/saturate stage for each of p2 and p3.
`default_nettype none

module glt_power #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  glt_pkg::item_t    in_item,
    output logic              out_valid,
    input  logic              out_ready,
    output glt_pkg::item_t    out_item,
    output glt_pkg::pow_vec_t out_pow
);
    import glt_pkg::*;

    localparam int MULT_COUNT = POLY_TERMS - 2;
    localparam int STAGES     = 2 * MULT_COUNT;
    localparam int PPROD_W    = POW_W + LEN_W;
    localparam int BIAS_W     = PPROD_W + 1;
    localparam logic [BIAS_W-1:0] POW_HALF = BIAS_W'(1) << (FRAC_BITS - 1);
    localparam logic [POW_W-1:0]  POW_ONE  = POW_W'(1) << FRAC_BITS;
    localparam logic [POW_W-1:0]  POW_MAX  = {POW_W{1'b1}};

    logic [STAGES-1:0]  valid_reg;
    logic [STAGES:0]    ready;
    item_t              item_reg [STAGES];
    pow_vec_t           pow_reg  [STAGES];
    logic [PPROD_W-1:0] prod_reg [STAGES];

    item_t              item_src [STAGES];
    pow_vec_t           pow_src  [STAGES];
    logic [STAGES-1:0]  valid_src;
    pow_vec_t           pow_init;

    // p0 is one, p1 is the leg length itself
    always_comb
    begin
        pow_init    = '0;
        pow_init[0] = POW_ONE;
        pow_init[1] = POW_W'(in_item.leg_length);
    end

    assign ready[STAGES] = out_ready;
    assign in_ready      = ready[0];

    for (genvar g = 0; g < STAGES; g++)
    begin : g_stage
        localparam int K = g / 2 + 2;

        pow_vec_t pow_next;

        // Stage source: module input for the first stage, previous register otherwise
        if (g == 0)
        begin : g_first
            assign item_src[g]  = in_item;
            assign pow_src[g]   = pow_init;
            assign valid_src[g] = in_valid;
        end
        else
        begin : g_chain
            assign item_src[g]  = item_reg[g-1];
            assign pow_src[g]   = pow_reg[g-1];
            assign valid_src[g] = valid_reg[g-1];
        end

        assign ready[g] = !valid_reg[g] || ready[g+1];

        if (g % 2 == 0)
        begin : g_mult
            // p(K-1) * leg length
            assign pow_next = pow_src[g];

            always_ff @(posedge clk)
            begin
                if (ready[g] && valid_src[g])
                begin
                    prod_reg[g] <= pow_src[g][K-1] * item_src[g].leg_length;
                end
            end
        end
        else
        begin : g_round
            logic [BIAS_W-1:0] biased;
            logic [BIAS_W-1:0] scaled;

            // Round half up, then clamp to the 31-bit unsigned range
            assign biased = {1'b0, prod_reg[g-1]} + POW_HALF;
            assign scaled = biased >> FRAC_BITS;

            always_comb
            begin
                pow_next    = pow_src[g];
                pow_next[K] = (|scaled[BIAS_W-1:POW_W]) ? POW_MAX : scaled[POW_W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[g] <= 1'b0;
            end
            else if (ready[g])
            begin
                valid_reg[g] <= valid_src[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ready[g] && valid_src[g])
            begin
                item_reg[g] <= item_src[g];
                pow_reg[g]  <= pow_next;
            end
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_item  = item_reg[STAGES-1];
    assign out_pow   = pow_reg[STAGES-1];

    // The low powers must travel unchanged alongside their request
    a_pow_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_pow[0] == POW_ONE))
        else $error("power p0 lost its unit value");

    a_pow_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_pow[1] == POW_W'(out_item.leg_length)))
        else $error("power p1 does not match the request leg length");

endmodule

`default_nettype wire

// File: hw/rtl/glt_gain.sv
// Coefficient table and the three-stage gain polynomial evaluation.
`default_nettype none

module glt_gain #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  glt_pkg::item_t     in_item,
    input  glt_pkg::pow_vec_t  in_pow,
    output logic               out_valid,
    input  logic               out_ready,
    output glt_pkg::ctx_t      out_ctx,
    output glt_pkg::gain_vec_t out_gain
);
    import glt_pkg::*;

    localparam int STAGES = 3;
    localparam int TERM_W = PROD_W - FRAC_BITS;
    localparam int SUM_W  = TERM_W + $clog2(POLY_TERMS) + 1;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

    // Coefficient table, no reset: entries must be read only after a load; the block does not enforce this
    word_t coef_mem [TABLE_DEPTH];

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   ready;
    ctx_t              ctx_reg [STAGES];
    logic signed [PROD_W-1:0] prod_reg [GAIN_ROWS][POLY_TERMS];
    logic signed [TERM_W-1:0] term_reg [GAIN_ROWS][POLY_TERMS];
    word_t                    gain_reg [GAIN_ROWS];

    logic signed [PROD_W-1:0] prod_next [GAIN_ROWS][POLY_TERMS];
    logic signed [TERM_W-1:0] term_next [GAIN_ROWS][POLY_TERMS];
    word_t                    gain_next [GAIN_ROWS];
    logic  tbl_we;
    logic  comp_valid;
    ctx_t  ctx_in;

    // Loads retire here in order with computes; they never block
    assign tbl_we     = in_valid && (in_item.action == ACT_LOAD)
                        && (in_item.coef_index < INDEX_W'(TABLE_DEPTH));
    assign comp_valid = in_valid && (in_item.action == ACT_COMPUTE);
    assign in_ready   = ready[0] || (in_item.action == ACT_LOAD);

    assign ctx_in.off_ground = in_item.off_ground;
    assign ctx_in.err        = in_item.err;

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            coef_mem[in_item.coef_index] <= in_item.coef_value;
        end
    end

    // Handshake chain
    assign ready[STAGES] = out_ready;
    for (genvar s = 0; s < STAGES; s++)
    begin : g_ready
        assign ready[s] = !valid_reg[s] || ready[s+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0]) valid_reg[0] <= comp_valid;
            if (ready[1]) valid_reg[1] <= valid_reg[0];
            if (ready[2]) valid_reg[2] <= valid_reg[1];
        end
    end

    // Stage 1: coefficient times power, column 0 pairs with the top power
    always_comb
    begin
        for (int r = 0; r < GAIN_ROWS; r++)
        begin
            for (int c = 0; c < POLY_TERMS; c++)
            begin
                prod_next[r][c] = coef_mem[INDEX_W'(r * POLY_TERMS + c)]
                                  * $signed({1'b0, in_pow[POLY_TERMS-1-c]});
            end
        end
    end

    // Stage 2: round each term half up
    always_comb
    begin
        for (int r = 0; r < GAIN_ROWS; r++)
        begin
            for (int c = 0; c < POLY_TERMS; c++)
            begin
                term_next[r][c] = TERM_W'((prod_reg[r][c] + ROUND_HALF) >>> FRAC_BITS);
            end
        end
    end

    // Stage 3: add the terms of each row and saturate to 32 bits
    always_comb
    begin
        logic signed [SUM_W-1:0] acc;
        for (int r = 0; r < GAIN_ROWS; r++)
        begin
            acc = '0;
            for (int c = 0; c < POLY_TERMS; c++)
            begin
                acc = acc + SUM_W'(term_reg[r][c]);
            end
            if ((&acc[SUM_W-1:WORD_W-1]) || !(|acc[SUM_W-1:WORD_W-1]))
            begin
                gain_next[r] = acc[WORD_W-1:0];
            end
            else if (acc[SUM_W-1])
            begin
                gain_next[r] = {1'b1, {(WORD_W-1){1'b0}}};
            end
            else
            begin
                gain_next[r] = {1'b0, {(WORD_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0] && comp_valid)
        begin
            ctx_reg[0] <= ctx_in;
            prod_reg   <= prod_next;
        end
        if (ready[1] && valid_reg[0])
        begin
            ctx_reg[1] <= ctx_reg[0];
            term_reg   <= term_next;
        end
        if (ready[2] && valid_reg[1])
        begin
            ctx_reg[2] <= ctx_reg[1];
            gain_reg   <= gain_next;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_ctx   = ctx_reg[STAGES-1];
    always_comb
    begin
        for (int r = 0; r < GAIN_ROWS; r++)
        begin
            out_gain[r] = gain_reg[r];
        end
    end

    // A load must retire in the cycle it arrives, whatever the stall state
    a_load_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && (in_item.action == ACT_LOAD)) |-> in_ready)
        else $error("coefficient load held back at the table");

endmodule

`default_nettype wire

// File: hw/rtl/glt_torque.sv
// Torque dot products: gain times error, rounding, summation and output saturation.
`default_nettype none

module glt_torque #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  glt_pkg::ctx_t             in_ctx,
    input  glt_pkg::gain_vec_t        in_gain,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [glt_pkg::WORD_W-1:0] out_wheel,
    output logic [glt_pkg::WORD_W-1:0] out_hip
);
    import glt_pkg::*;

    localparam int STAGES = 4;
    localparam int TERM_W = PROD_W - FRAC_BITS;
    localparam int TSUM_W = TERM_W + $clog2(STATE_COUNT) + 1;
    localparam int NEG_W  = TSUM_W + 1;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   ready;
    logic [2:0]        off_reg;
    logic signed [PROD_W-1:0] prod_reg [GAIN_ROWS];
    logic signed [TERM_W-1:0] term_reg [GAIN_ROWS];
    logic signed [TSUM_W-1:0] wheel_sum_reg;
    logic signed [TSUM_W-1:0] hip_sum_reg;
    logic [WORD_W-1:0]        wheel_reg;
    logic [WORD_W-1:0]        hip_reg;

    logic signed [PROD_W-1:0] prod_next [GAIN_ROWS];
    logic signed [TERM_W-1:0] term_next [GAIN_ROWS];
    logic signed [TSUM_W-1:0] wheel_sum_next;
    logic signed [TSUM_W-1:0] hip_sum_next;
    logic [WORD_W-1:0]        wheel_next;
    logic [WORD_W-1:0]        hip_next;
    logic signed [NEG_W-1:0]  hip_neg;

    assign in_ready      = ready[0];
    assign ready[STAGES] = out_ready;
    for (genvar s = 0; s < STAGES; s++)
    begin : g_ready
        assign ready[s] = !valid_reg[s] || ready[s+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0]) valid_reg[0] <= in_valid;
            if (ready[1]) valid_reg[1] <= valid_reg[0];
            if (ready[2]) valid_reg[2] <= valid_reg[1];
            if (ready[3]) valid_reg[3] <= valid_reg[2];
        end
    end

    // Stage 1: even rows are wheel gains, odd rows hip gains, both for error r/2
    always_comb
    begin
        for (int r = 0; r < GAIN_ROWS; r++)
        begin
            prod_next[r] = in_gain[r] * in_ctx.err[r >> 1];
        end
    end

    // Stage 2: round, and drop the terms that do not count off ground
    always_comb
    begin
        for (int r = 0; r < GAIN_ROWS; r++)
        begin
            term_next[r] = TERM_W'((prod_reg[r] + ROUND_HALF) >>> FRAC_BITS);
            if (off_reg[0] && (((r & 1) == 0) || ((r >> 1) >= 2)))
            begin
                term_next[r] = '0;
            end
        end
    end

    // Stage 3: the two dot-product sums
    always_comb
    begin
        wheel_sum_next = '0;
        hip_sum_next   = '0;
        for (int j = 0; j < STATE_COUNT; j++)
        begin
            wheel_sum_next = wheel_sum_next + TSUM_W'(term_reg[2*j]);
            hip_sum_next   = hip_sum_next + TSUM_W'(term_reg[2*j+1]);
        end
    end

    // Stage 4: negate the hip sum, saturate both, force wheel to zero off ground
    assign hip_neg = -NEG_W'(hip_sum_reg);

    always_comb
    begin
        if (off_reg[2])
        begin
            wheel_next = '0;
        end
        else if ((&wheel_sum_reg[TSUM_W-1:WORD_W-1]) || !(|wheel_sum_reg[TSUM_W-1:WORD_W-1]))
        begin
            wheel_next = wheel_sum_reg[WORD_W-1:0];
        end
        else
        begin
            wheel_next = wheel_sum_reg[TSUM_W-1] ? SAT_MIN : SAT_MAX;
        end

        if ((&hip_neg[NEG_W-1:WORD_W-1]) || !(|hip_neg[NEG_W-1:WORD_W-1]))
        begin
            hip_next = hip_neg[WORD_W-1:0];
        end
        else
        begin
            hip_next = hip_neg[NEG_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[0] && in_valid)
        begin
            off_reg[0] <= in_ctx.off_ground;
            prod_reg   <= prod_next;
        end
        if (ready[1] && valid_reg[0])
        begin
            off_reg[1] <= off_reg[0];
            term_reg   <= term_next;
        end
        if (ready[2] && valid_reg[1])
        begin
            off_reg[2]    <= off_reg[1];
            wheel_sum_reg <= wheel_sum_next;
            hip_sum_reg   <= hip_sum_next;
        end
        if (ready[3] && valid_reg[2])
        begin
            wheel_reg <= wheel_next;
            hip_reg   <= hip_next;
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_wheel = wheel_reg;
    assign out_hip   = hip_reg;

    // Off ground the wheel result is always zero
    a_off_wheel: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[2] && ready[3] && off_reg[2]) |=> (wheel_reg == '0))
        else $error("wheel torque not zero off ground");

    // A zero hip sum stays zero after negation and saturation
    a_hip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[2] && ready[3] && (hip_sum_reg == '0)) |=> (hip_reg == '0))
        else $error("hip torque negation broke a zero sum");

endmodule

`default_nettype wire
